/* rtl/core/cfr_pkg.sv */
// Package: shared types and constants for the CAN fragment reassembly block.
package cfr_pkg;
    localparam int SLOTS_DEF     = 8;
    localparam int MSG_BYTES_DEF = 32;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_NONE   = 2'd2
    } t_kind;

    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_FETCH = 1'b1
    } t_cmd;

    localparam logic [0:0] REG_NODE  = 1'b0;
    localparam logic [0:0] REG_BCAST = 1'b1;

    // request handed from front to back
    typedef struct packed {
        logic       fetch;
        logic       drop;
        logic [7:0] src;
        logic [3:0] part;
        logic [3:0] total;
        logic [2:0] mid;
        logic [3:0] len;
        logic [63:0] bytes;
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_STATUS,
        ST_READ,
        ST_EMIT
    } t_state;
endpackage

/* rtl/core/can_fragment_reassembly.sv */
// Top level: CAN multi-frame reassembly buffer.
// Input channel (i_valid/o_ready) takes one request: a received frame
// (command 0) or a fetch of one completed message (command 1).
// Output channel (o_valid/i_ready) returns results; o_last marks the
// final result of each request.
// Config channel (i_cfg_valid/o_cfg_ready) writes node address (index 0)
// or broadcast address (index 1); it is always ready.
// A two-entry queue sits between the filter front end and the slot engine.
// A frame passes from the queue through a slot scan, byte appends on the
// single memory write port and a part-count update to its status result; a
// dropped frame goes from the scan straight to its status result.
// A fetch alternates a registered read of the byte memory with the emit of
// each message byte (an empty message yields one byte result); a fetch with
// no ready message returns a single result of kind none.
// Reset (synchronous, active low) frees all slots and restores the
// address registers; byte memory is not cleared.
// A stalled receiver holds the current result; the front keeps taking
// requests until the queue is full.
module can_fragment_reassembly #(
    parameter int SLOTS     = cfr_pkg::SLOTS_DEF,
    parameter int MSG_BYTES = cfr_pkg::MSG_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [28:0] i_frame_id,
    input  logic [3:0]  i_frame_len,
    input  logic [7:0]  i_byte_0,
    input  logic [7:0]  i_byte_1,
    input  logic [7:0]  i_byte_2,
    input  logic [7:0]  i_byte_3,
    input  logic [7:0]  i_byte_4,
    input  logic [7:0]  i_byte_5,
    input  logic [7:0]  i_byte_6,
    input  logic [7:0]  i_byte_7,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_slot_index,
    output logic        o_complete,
    output logic        o_evicted,
    output logic        o_dropped,
    output logic        o_overflow,
    output logic [7:0]  o_data_byte,
    output logic [5:0]  o_message_len,
    output logic        o_last
);
    import cfr_pkg::*;

    logic [7:0] r_node, r_bcast;
    logic w_qv, w_pop;
    t_req w_qreq;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node  <= 8'd0;
            r_bcast <= 8'hFF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_NODE:  r_node  <= i_cfg_data;
                REG_BCAST: r_bcast <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cfr_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_command, .i_frame_id, .i_frame_len,
        .i_bytes({i_byte_7, i_byte_6, i_byte_5, i_byte_4,
                  i_byte_3, i_byte_2, i_byte_1, i_byte_0}),
        .i_node(r_node), .i_bcast(r_bcast),
        .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_req(w_qreq)
    );

    cfr_back #(.SLOTS(SLOTS), .MSG_BYTES(MSG_BYTES)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .i_q_req(w_qreq), .o_q_pop(w_pop),
        .o_valid, .i_ready, .o_kind, .o_slot_index, .o_complete, .o_evicted,
        .o_dropped, .o_overflow, .o_data_byte, .o_message_len, .o_last
    );
endmodule

/* rtl/core/cfr_front.sv */
// Front end: accepts requests, filters destination, pushes into a short queue.
module cfr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_command,
    input  logic [28:0]    i_frame_id,
    input  logic [3:0]     i_frame_len,
    input  logic [63:0]    i_bytes,
    input  logic [7:0]     i_node,
    input  logic [7:0]     i_bcast,
    output logic           o_q_valid,
    input  logic           i_q_pop,
    output cfr_pkg::t_req  o_q_req
);
    import cfr_pkg::*;

    t_req r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_req w_req;
    logic [7:0] w_dst;
    logic w_push;

    assign w_dst          = i_frame_id[15:8];
    always_comb begin
        w_req.fetch = (i_command == CMD_FETCH);
        w_req.drop  = (i_command == CMD_FRAME) && (w_dst != i_node) && (w_dst != i_bcast);
        w_req.src   = i_frame_id[7:0];
        w_req.part  = i_frame_id[19:16];
        w_req.total = i_frame_id[23:20];
        w_req.mid   = i_frame_id[26:24];
        w_req.len   = (i_frame_len > 4'd8) ? 4'd8 : i_frame_len;
        w_req.bytes = i_bytes;
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_req;
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !o_ready) else $error("ready while full");
endmodule

/* rtl/core/cfr_back.sv */
// Back end: slot table, byte memory, frame append and message fetch sequencer.
module cfr_back #(
    parameter int SLOTS     = cfr_pkg::SLOTS_DEF,
    parameter int MSG_BYTES = cfr_pkg::MSG_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  cfr_pkg::t_req i_q_req,
    output logic          o_q_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_kind,
    output logic [2:0]    o_slot_index,
    output logic          o_complete,
    output logic          o_evicted,
    output logic          o_dropped,
    output logic          o_overflow,
    output logic [7:0]    o_data_byte,
    output logic [5:0]    o_message_len,
    output logic          o_last
);
    import cfr_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BW = $clog2(MSG_BYTES);
    localparam int LW = $clog2(MSG_BYTES + 1);

    t_state r_st, n_st;
    logic [SLOTS-1:0] r_lock, r_rdy;
    logic [LW-1:0] r_len [SLOTS];
    logic [7:0]    r_src [SLOTS];
    logic [2:0]    r_mid [SLOTS];
    logic [3:0]    r_parts [SLOTS];
    logic [7:0]    r_age [SLOTS];
    logic [7:0]    r_mem [SLOTS*(2**BW)];

    t_req r_req;
    logic [SW-1:0] r_slot;
    logic          r_found, r_evic, r_ovf, r_comp;
    logic [3:0]    r_k;
    logic [LW-1:0] r_idx, r_mlen;
    logic [7:0]    r_rd;

    // ages as they stand after a part 0 claim ages every locked slot
    logic [7:0] w_age_nx [SLOTS];
    always_comb begin
        for (int s = 0; s < SLOTS; s++)
            w_age_nx[s] = (r_age[s] == 8'hFF) ? 8'hFF : r_age[s] + 8'd1;
    end

    // combinational selection over the slot table
    logic [SW-1:0] w_free, w_old, w_match, w_rsel;
    logic w_has_free, w_has_match, w_has_rdy;
    always_comb begin
        w_free = '0; w_has_free = 1'b0;
        w_match = '0; w_has_match = 1'b0;
        w_rsel = '0; w_has_rdy = 1'b0;
        w_old = '0;
        for (int s = 0; s < SLOTS; s++) begin
            if (!r_lock[s]) begin
                w_free = SW'(s); w_has_free = 1'b1;
            end
            if (r_lock[s] && r_src[s] == r_req.src && r_mid[s] == r_req.mid
                && r_parts[s] == r_req.part) begin
                w_match = SW'(s); w_has_match = 1'b1;
            end
            if (r_rdy[s]) begin
                w_rsel = SW'(s); w_has_rdy = 1'b1;
            end
            if (w_age_nx[s] > w_age_nx[w_old]) w_old = SW'(s);
        end
    end

    logic [BW+SW-1:0] w_addr;
    logic [7:0]       w_wbyte;
    logic             w_wen;
    assign w_wbyte = r_req.bytes[8*r_k[2:0] +: 8];
    assign w_wen   = (r_st == ST_WRITE) && (r_k < r_req.len)
                     && (r_len[r_slot] < LW'(MSG_BYTES));
    assign w_addr  = (r_st == ST_WRITE) ? {r_slot, r_len[r_slot][BW-1:0]}
                                        : {r_slot, r_idx[BW-1:0]};

    always_ff @(posedge i_clk) begin
        if (w_wen) r_mem[w_addr] <= w_wbyte;
        r_rd <= r_mem[w_addr];
    end

    always_comb begin
        n_st = r_st;
        o_q_pop = 1'b0;
        case (r_st)
            ST_IDLE: if (i_q_valid) begin
                o_q_pop = 1'b1;
                n_st = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_req.fetch) n_st = w_has_rdy ? ST_READ : ST_STATUS;
                else if (r_req.drop) n_st = ST_STATUS;
                else if (r_req.part == 4'd0 || w_has_match) n_st = ST_WRITE;
                else n_st = ST_STATUS;
            end
            ST_WRITE: if (r_k == 4'd8) n_st = ST_STATUS;
            ST_STATUS: if (i_ready) n_st = ST_IDLE;
            ST_READ: n_st = ST_EMIT;
            ST_EMIT: if (i_ready)
                n_st = (r_idx + LW'(1) >= r_mlen) ? ST_IDLE : ST_READ;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_lock <= '0;
            r_rdy  <= '0;
            r_slot <= '0;
            for (int s = 0; s < SLOTS; s++) begin
                r_len[s] <= '0; r_src[s] <= '0; r_mid[s] <= '0;
                r_parts[s] <= '0; r_age[s] <= '0;
            end
        end else begin
            r_st <= n_st;
            case (r_st)
                ST_IDLE: if (i_q_valid) begin
                    r_req <= i_q_req;
                    r_k <= '0; r_evic <= 1'b0; r_ovf <= 1'b0; r_comp <= 1'b0;
                    r_found <= 1'b0; r_idx <= '0;
                end
                ST_SCAN: begin
                    if (r_req.fetch) begin
                        r_slot <= w_rsel;
                        r_found <= w_has_rdy;
                        r_mlen <= r_len[w_rsel];
                    end else if (!r_req.drop && r_req.part == 4'd0) begin
                        for (int s = 0; s < SLOTS; s++)
                            if (r_lock[s] && r_age[s] != 8'hFF) r_age[s] <= r_age[s] + 8'd1;
                        r_found <= 1'b1;
                        if (w_has_free) begin
                            r_slot <= w_free;
                            r_len[w_free] <= '0; r_parts[w_free] <= '0;
                            r_rdy[w_free] <= 1'b0; r_age[w_free] <= '0;
                            r_lock[w_free] <= 1'b1;
                            r_src[w_free] <= r_req.src; r_mid[w_free] <= r_req.mid;
                        end else begin
                            r_slot <= w_old;
                            r_evic <= 1'b1;
                            r_len[w_old] <= '0; r_parts[w_old] <= '0;
                            r_rdy[w_old] <= 1'b0; r_age[w_old] <= '0;
                            r_lock[w_old] <= 1'b1;
                            r_src[w_old] <= r_req.src; r_mid[w_old] <= r_req.mid;
                        end
                    end else if (!r_req.drop && w_has_match) begin
                        r_slot <= w_match;
                        r_found <= 1'b1;
                    end
                end
                ST_WRITE: begin
                    if (r_k == 4'd8) begin
                        r_parts[r_slot] <= r_parts[r_slot] + 4'd1;
                        if (r_parts[r_slot] + 4'd1 == r_req.total) begin
                            r_rdy[r_slot] <= 1'b1;
                            r_comp <= 1'b1;
                        end
                    end else begin
                        r_k <= r_k + 4'd1;
                        if (r_k < r_req.len) begin
                            if (w_wen) r_len[r_slot] <= r_len[r_slot] + LW'(1);
                            else r_ovf <= 1'b1;
                        end
                    end
                end
                ST_EMIT: if (i_ready) begin
                    r_idx <= r_idx + LW'(1);
                    if (r_idx + LW'(1) >= r_mlen) begin
                        r_lock[r_slot] <= 1'b0; r_rdy[r_slot] <= 1'b0;
                        r_len[r_slot] <= '0; r_src[r_slot] <= '0;
                        r_mid[r_slot] <= '0; r_parts[r_slot] <= '0;
                        r_age[r_slot] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_valid = (r_st == ST_STATUS) || (r_st == ST_EMIT);
        o_kind = KIND_STATUS;
        o_slot_index = '0; o_complete = 1'b0; o_evicted = 1'b0;
        o_dropped = 1'b0; o_overflow = 1'b0; o_data_byte = '0;
        o_message_len = '0; o_last = 1'b1;
        if (r_st == ST_EMIT) begin
            o_kind = KIND_BYTE;
            o_slot_index = 3'(r_slot);
            o_data_byte = (r_mlen == '0) ? 8'd0 : r_rd;
            o_message_len = 6'(r_mlen);
            o_last = (r_idx + LW'(1) >= r_mlen);
        end else if (r_req.fetch) begin
            o_kind = KIND_NONE;
        end else if (r_found) begin
            o_slot_index = 3'(r_slot);
            o_complete = r_comp; o_evicted = r_evic; o_overflow = r_ovf;
        end else begin
            o_dropped = 1'b1;
        end
    end

    a_emit_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_EMIT) |-> r_rdy[r_slot]) else $error("emitting from non-ready slot");
    a_ready_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rdy & ~r_lock) == '0) else $error("ready slot not locked");
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len[r_slot] <= LW'(MSG_BYTES)) else $error("slot length above capacity");
endmodule

/* sim/can_fragment_reassembly_tb.sv */
// Testbench: random and directed frame/fetch traffic against a slot-buffer predictor.
`timescale 1ns / 100ps

typedef struct {
    logic [1:0] kind;
    logic [2:0] slot;
    logic       comp;
    logic       evic;
    logic       drop;
    logic       ovf;
    logic [7:0] data;
    logic [5:0] mlen;
    logic       last;
} t_res;

class cfr_scoreboard;
    logic [7:0] node_addr;
    logic [7:0] bcast_addr;
    bit         locked [8];
    bit         rdy    [8];
    int         length [8];
    logic [7:0] source [8];
    logic [2:0] msg_id [8];
    logic [3:0] parts  [8];
    int         age    [8];
    logic [7:0] mem    [8][32];
    t_res       pending[$];
    int         errors;

    function void reset_state();
        node_addr = 8'd0;
        bcast_addr = 8'd255;
        for (int s = 0; s < 8; s++) clear(s);
        pending.delete();
    endfunction

    function void clear(int s);
        locked[s] = 0; rdy[s] = 0; length[s] = 0; source[s] = 0;
        msg_id[s] = 0; parts[s] = 0; age[s] = 0;
    endfunction

    function void push(int kind, int slot, bit comp, bit evic, bit drop, bit ovf,
                       int data, int mlen, bit last);
        t_res r;
        r.kind = 2'(kind); r.slot = 3'(slot); r.comp = comp; r.evic = evic;
        r.drop = drop; r.ovf = ovf; r.data = 8'(data); r.mlen = 6'(mlen);
        r.last = last;
        pending.push_back(r);
    endfunction

    function int ready_count();
        int n;
        n = 0;
        for (int s = 0; s < 8; s++) if (rdy[s]) n++;
        return n;
    endfunction

    function void note_request(bit cmd, logic [28:0] id, logic [3:0] flen,
                               logic [7:0] b [8]);
        int found, n, slot, len;
        bit evic, ovf, comp;
        logic [7:0] src, dst;
        logic [3:0] part, total;
        logic [2:0] mid;
        found = -1; slot = -1; evic = 0; ovf = 0; comp = 0;
        if (cmd == cfr_pkg::CMD_FETCH) begin
            for (int s = 0; s < 8; s++) if (rdy[s]) found = s;
            if (found < 0) begin
                push(cfr_pkg::KIND_NONE, 0, 0, 0, 0, 0, 0, 0, 1);
                return;
            end
            len = length[found];
            if (len == 0) push(cfr_pkg::KIND_BYTE, found, 0, 0, 0, 0, 0, 0, 1);
            for (int k = 0; k < len; k++)
                push(cfr_pkg::KIND_BYTE, found, 0, 0, 0, 0, mem[found][k], len, k + 1 == len);
            clear(found);
            return;
        end
        src = id[7:0]; dst = id[15:8]; part = id[19:16]; total = id[23:20]; mid = id[26:24];
        n = (flen > 8) ? 8 : flen;
        if (dst != node_addr && dst != bcast_addr) begin
            push(cfr_pkg::KIND_STATUS, 0, 0, 0, 1, 0, 0, 0, 1);
            return;
        end
        if (part == 0) begin
            for (int s = 0; s < 8; s++) begin
                if (locked[s]) begin
                    if (age[s] < 255) age[s]++;
                end else begin
                    slot = s;
                end
            end
            if (slot < 0) begin
                slot = 0;
                for (int s = 1; s < 8; s++) if (age[s] > age[slot]) slot = s;
                clear(slot);
                evic = 1;
            end
            locked[slot] = 1; source[slot] = src; msg_id[slot] = mid;
        end else begin
            for (int s = 0; s < 8; s++)
                if (locked[s] && source[s] == src && msg_id[s] == mid && parts[s] == part)
                    slot = s;
            if (slot < 0) begin
                push(cfr_pkg::KIND_STATUS, 0, 0, 0, 1, 0, 0, 0, 1);
                return;
            end
        end
        for (int k = 0; k < n; k++) begin
            if (length[slot] < 32) begin
                mem[slot][length[slot]] = b[k];
                length[slot]++;
            end else begin
                ovf = 1;
            end
        end
        parts[slot] = parts[slot] + 4'd1;
        if (parts[slot] == total) begin
            rdy[slot] = 1;
            comp = 1;
        end
        push(cfr_pkg::KIND_STATUS, slot, comp, evic, 0, ovf, 0, 0, 1);
    endfunction

    function void report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endfunction

    function void check_result(t_res g);
        t_res e;
        if (pending.size() == 0) begin
            report("unexpected result kind", g.kind, -1);
            return;
        end
        e = pending.pop_front();
        if (g.kind != e.kind) report("kind", g.kind, e.kind);
        if (g.slot != e.slot) report("slot_index", g.slot, e.slot);
        if (g.comp != e.comp) report("complete", g.comp, e.comp);
        if (g.evic != e.evic) report("evicted", g.evic, e.evic);
        if (g.drop != e.drop) report("dropped", g.drop, e.drop);
        if (g.ovf != e.ovf) report("overflow", g.ovf, e.ovf);
        if (g.data != e.data) report("data_byte", g.data, e.data);
        if (g.mlen != e.mlen) report("message_len", g.mlen, e.mlen);
        if (g.last != e.last) report("last", g.last, e.last);
    endfunction
endclass

module can_fragment_reassembly_tb;
    import cfr_pkg::*;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready, i_command;
    logic [28:0] i_frame_id;
    logic [3:0]  i_frame_len;
    logic [7:0]  i_byte_0, i_byte_1, i_byte_2, i_byte_3;
    logic [7:0]  i_byte_4, i_byte_5, i_byte_6, i_byte_7;
    logic        i_cfg_valid, o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        o_valid, i_ready;
    logic [1:0]  o_kind;
    logic [2:0]  o_slot_index;
    logic        o_complete, o_evicted, o_dropped, o_overflow, o_last;
    logic [7:0]  o_data_byte;
    logic [5:0]  o_message_len;

    cfr_scoreboard board;
    int  send_idle, recv_stall;
    bit  hold_recv;
    int  quiet;
    bit  run_done;

    can_fragment_reassembly u_dut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            t_res r;
            r.kind = o_kind; r.slot = o_slot_index; r.comp = o_complete;
            r.evic = o_evicted; r.drop = o_dropped; r.ovf = o_overflow;
            r.data = o_data_byte; r.mlen = o_message_len; r.last = o_last;
            board.check_result(r);
        end
    end

    always @(negedge i_clk) begin
        if (hold_recv) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_stall);
    end

    // watchdog on acceptance
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready) ||
            run_done)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("can_fragment_reassembly verification failed");
            $finish;
        end
    end

    // valid stays high after a request until the next request or an idle cycle
    task automatic send_req(bit cmd, logic [28:0] id, logic [3:0] flen, logic [63:0] pay);
        logic [7:0] b [8];
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        for (int k = 0; k < 8; k++) b[k] = pay[8*k +: 8];
        i_valid <= 1'b1; i_command <= cmd; i_frame_id <= id; i_frame_len <= flen;
        i_byte_0 <= b[0]; i_byte_1 <= b[1]; i_byte_2 <= b[2]; i_byte_3 <= b[3];
        i_byte_4 <= b[4]; i_byte_5 <= b[5]; i_byte_6 <= b[6]; i_byte_7 <= b[7];
        do @(posedge i_clk); while (!o_ready);
        board.note_request(cmd, id, flen, b);
        @(negedge i_clk);
    endtask

    function automatic logic [28:0] make_id(int src, int dst, int part, int total, int mid);
        return {2'($urandom_range(3)), 3'(mid), 4'(total), 4'(part), 8'(dst), 8'(src)};
    endfunction

    function automatic logic [63:0] rand_pay();
        return {$urandom, $urandom};
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [7:0] val);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_NODE) board.node_addr = val;
        else board.bcast_addr = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic int pick_dst();
        int r;
        r = $urandom_range(9);
        if (r < 5) return board.node_addr;
        if (r < 8) return board.bcast_addr;
        return $urandom_range(255);
    endfunction

    // whole message from one source: parts 0..total-1, sometimes broken
    task automatic send_message(int total);
        int src, mid;
        src = $urandom_range(3) * 60 + $urandom_range(1);
        mid = $urandom_range(7);
        for (int p = 0; p < total; p++) begin
            int pp;
            pp = ($urandom_range(19) == 0) ? $urandom_range(15) : p;
            send_req(CMD_FRAME, make_id(src, pick_dst(), pp, total, mid),
                     4'(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8)),
                     rand_pay());
        end
    endtask

    task automatic random_phase(int items);
        int sent;
        sent = 0;
        while (sent < items) begin
            int r;
            r = $urandom_range(9);
            if (r < 5) begin
                int t;
                t = $urandom_range(1, 5);
                send_message(t);
                sent += t;
            end else if (r < 8) begin
                send_req(CMD_FETCH, 29'($urandom), 4'($urandom), rand_pay());
                sent++;
            end else begin
                send_req(CMD_FRAME, 29'($urandom), 4'($urandom), rand_pay());
                sent++;
            end
        end
    endtask

    initial begin
        board = new();
        board.reset_state();
        board.errors = 0;
        i_rst_n = 0; i_valid = 0; i_command = 0; i_frame_id = 0; i_frame_len = 0;
        i_byte_0 = 0; i_byte_1 = 0; i_byte_2 = 0; i_byte_3 = 0;
        i_byte_4 = 0; i_byte_5 = 0; i_byte_6 = 0; i_byte_7 = 0;
        i_cfg_valid = 0; i_cfg_index = 0; i_cfg_data = 0; i_ready = 0;
        send_idle = 0; recv_stall = 0; hold_recv = 0; quiet = 0; run_done = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed
        send_req(CMD_FETCH, '0, '0, '0);
        send_req(CMD_FRAME, make_id(1, 77, 0, 1, 0), 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(CMD_FRAME, make_id(2, 0, 0, 0, 7), '0, '0);
        send_req(CMD_FRAME, {2'b11, 3'd7, 4'd3, 4'd0, 8'd255, 8'd255}, 4'd15,
                 64'h0123_4567_89AB_CDEF);
        for (int p = 1; p < 5; p++)
            send_req(CMD_FRAME, make_id(255, 255, p, 5, 7), 4'd8, rand_pay());
        for (int i = 0; i < 8; i++)
            send_req(CMD_FRAME, make_id(10 + i, 0, 0, 2, i), 4'd4, rand_pay());
        send_req(CMD_FRAME, make_id(99, 0, 9, 10, 1), 4'd8, rand_pay());
        for (int i = 0; i < 4; i++) send_req(CMD_FETCH, '0, '0, '0);
        drain();

        write_reg(REG_NODE, 8'd255);
        write_reg(REG_BCAST, 8'd0);
        send_idle = 0; recv_stall = 0;
        random_phase(60);
        drain();

        write_reg(REG_NODE, 8'd42);
        write_reg(REG_BCAST, 8'd170);
        send_idle = 70; recv_stall = 0;
        random_phase(60);
        drain();

        // long receiver hold so the block backs up its input
        fork
            begin
                hold_recv = 1;
                repeat (400) @(negedge i_clk);
                hold_recv = 0;
            end
            begin
                send_idle = 0;
                random_phase(20);
                i_valid <= 1'b0;
            end
        join
        drain();

        write_reg(REG_NODE, 8'd0);
        write_reg(REG_BCAST, 8'd255);
        send_idle = 0; recv_stall = 70;
        random_phase(60);
        drain();

        write_reg(REG_NODE, 8'($urandom_range(255)));
        send_idle = 26; recv_stall = 26;
        random_phase(60);
        drain();
        send_idle = 0; recv_stall = 0;
        random_phase(30);
        while (board.ready_count() > 0) send_req(CMD_FETCH, '0, '0, '0);

        drain();
        run_done = 1;
        if (board.errors == 0 && board.pending.size() == 0)
            $display("can_fragment_reassembly verification clean");
        else
            $display("can_fragment_reassembly verification failed");
        $finish;
    end
endmodule

/* sim.f */
rtl/core/cfr_pkg.sv
rtl/core/cfr_front.sv
rtl/core/cfr_back.sv
rtl/core/can_fragment_reassembly.sv
sim/can_fragment_reassembly_tb.sv
